/* design/gmsk_rx_front_end_defines.svh */
// Assertion helpers shared by the receive front end.
`ifndef GMSK_RX_FRONT_END_DEFINES_SVH
`define GMSK_RX_FRONT_END_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define GMSKRX_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define GMSKRX_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/gmskrx_pkg.sv */
package gmskrx_pkg;

  // Fixed Gaussian taps, Q15
  localparam int COEF_COUNT = 12;
  localparam int COEF_IDX_W = 6;
  localparam logic signed [15:0] COEF_TABLE [COEF_COUNT] = '{
    16'sd8, 16'sd104, 16'sd760, 16'sd3158, 16'sd7421, 16'sd9866,
    16'sd7421, 16'sd3158, 16'sd760, 16'sd104, 16'sd8, 16'sd0
  };

  localparam logic [15:0] DC_BIAS = 16'd2048;

  typedef logic [COEF_IDX_W-1:0] coef_idx_t;

  typedef enum logic [1:0] {
    REG_GAIN   = 2'd0,
    REG_INVERT = 2'd1,
    REG_ENABLE = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic mul_en;
    logic acc_clr;
    logic acc_en;
  } mac_ctrl_t;

  typedef struct packed {
    logic shift;
    logic rotate;
  } hist_ctrl_t;

  // Taps past the end of the table are zero.
  function automatic logic signed [15:0] coef_lookup(coef_idx_t k);
    logic signed [15:0] c;
    c = 16'sd0;
    if (k < coef_idx_t'(COEF_COUNT)) begin
      c = COEF_TABLE[k[3:0]];
    end
    return c;
  endfunction

  function automatic logic signed [15:0] sat16(logic signed [31:0] v);
    logic signed [15:0] r;
    if (v > 32'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -32'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

/* design/gmskrx_mac.sv */
module gmskrx_mac import gmskrx_pkg::*; (
  input  logic               clk_i,
  input  mac_ctrl_t          ctrl_i,
  input  logic signed [15:0] a_i,
  input  logic signed [15:0] b_i,
  output logic signed [31:0] prod_o,
  output logic signed [31:0] acc_o
);

  logic signed [31:0] prod_q, prod_d;
  logic signed [31:0] acc_q, acc_d;

  always_comb begin
    prod_d = ctrl_i.mul_en ? (a_i * b_i) : prod_q;
    acc_d  = acc_q;
    if (ctrl_i.acc_clr) begin
      acc_d = '0;
    end else if (ctrl_i.acc_en) begin
      // 32-bit wrap
      acc_d = acc_q + prod_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    acc_q  <= acc_d;
  end

  assign prod_o = prod_q;
  assign acc_o  = acc_q;

endmodule

/* design/gmskrx_hist.sv */
module gmskrx_hist import gmskrx_pkg::*; #(
  parameter int TAPS = 12
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  hist_ctrl_t         ctrl_i,
  input  logic signed [15:0] din_i,
  output logic signed [15:0] head_o
);

  logic signed [15:0] hist_q [TAPS];
  logic signed [15:0] hist_d [TAPS];

  // Shift pushes the newest sample at the head; rotate walks the line
  // toward the head so every entry passes the single read tap.
  always_comb begin
    for (int i = 0; i < TAPS; i++) begin
      hist_d[i] = hist_q[i];
    end
    if (ctrl_i.shift) begin
      hist_d[0] = din_i;
      for (int i = 1; i < TAPS; i++) begin
        hist_d[i] = hist_q[i-1];
      end
    end else if (ctrl_i.rotate) begin
      for (int i = 0; i < TAPS - 1; i++) begin
        hist_d[i] = hist_q[i+1];
      end
      hist_d[TAPS-1] = hist_q[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TAPS; i++) begin
        hist_q[i] <= '0;
      end
    end else begin
      for (int i = 0; i < TAPS; i++) begin
        hist_q[i] <= hist_d[i];
      end
    end
  end

  assign head_o = hist_q[0];

endmodule

/* design/gmsk_rx_front_end.sv */
// Each enabled sample walks IDLE, SCALE, STORE, one MAC step per tap, DRAIN and DONE;
// filtered_valid_o is registered and rises after DONE hands the result to the output register.
// No new sample is taken until DONE has handed the result on, which back-pressure can hold;
// the single shared multiplier forms one scaling product, then one tap product per cycle.
// A sample taken while disabled is dropped in its accept cycle.
// Reset (rst_ni low, async): gain 128, invert 0, enable 0, history zeroed,
// no output beat pending.
`include "gmsk_rx_front_end_defines.svh"

module gmsk_rx_front_end import gmskrx_pkg::*; #(
  parameter int TAPS = 12
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration writes
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [7:0]         cfg_data_i,
  // raw sample beats
  input  logic               sample_valid_i,
  output logic               sample_ready_o,
  input  logic signed [15:0] sample_i,
  // filtered beats
  output logic               filtered_valid_o,
  input  logic               filtered_ready_i,
  output logic signed [15:0] filtered_o
);

  localparam int KW = $clog2(TAPS);
  localparam logic [KW-1:0] KLAST = KW'(TAPS - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCALE,
    ST_STORE,
    ST_MAC,
    ST_DRAIN,
    ST_DONE
  } state_e;

  state_e             state_q, state_d;
  logic [KW-1:0]      k_q, k_d;
  logic signed [15:0] cent_q, cent_d;
  logic               out_valid_q, out_valid_d;
  logic signed [15:0] out_q, out_d;

  logic [7:0]         gain_q;
  logic               invert_q;
  logic               enable_q;

  logic               in_beat;
  logic [15:0]        raw;
  logic signed [15:0] centered;
  logic signed [15:0] scaled;
  logic signed [15:0] result;
  logic signed [15:0] mul_a, mul_b;
  logic signed [31:0] prod;
  logic signed [31:0] acc;
  logic signed [15:0] hist_head;
  mac_ctrl_t          mac_ctrl;
  hist_ctrl_t         hist_ctrl;

  // ------------------------------------------------------------------
  // Configuration registers: written only while idle, a user rule the block leaves unenforced; no read-back.
  // ------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q   <= 8'd128;
      invert_q <= 1'b0;
      enable_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_GAIN:   gain_q   <= cfg_data_i;
        REG_INVERT: invert_q <= cfg_data_i[0];
        REG_ENABLE: enable_q <= cfg_data_i[0];
        default: ; // ignore writes past the register list
      endcase
    end
  end

  // ------------------------------------------------------------------
  // Front conditioning: optional negate, then DC removal, both wrapping.
  // ------------------------------------------------------------------
  assign in_beat  = sample_valid_i && sample_ready_o;
  assign raw      = invert_q ? (16'd0 - sample_i) : sample_i;
  assign centered = raw - DC_BIAS;

  // Gain scaling: (c * g * 128) >>> 15 equals (c * g) >>> 8.
  assign scaled = sat16(prod >>> 8);
  // FIR output: accumulator >>> 15, saturated.
  assign result = sat16(acc >>> 15);

  // ------------------------------------------------------------------
  // Shared multiplier operand select and unit controls.
  // ------------------------------------------------------------------
  always_comb begin
    if (state_q == ST_SCALE) begin
      mul_a = cent_q;
      mul_b = signed'({8'd0, gain_q});
    end else begin
      mul_a = hist_head;
      mul_b = coef_lookup(coef_idx_t'(k_q));
    end
    mac_ctrl.mul_en  = (state_q == ST_SCALE) || (state_q == ST_MAC);
    mac_ctrl.acc_clr = (state_q == ST_STORE);
    // The first tap cycle still holds the scaling product: skip it.
    mac_ctrl.acc_en  = ((state_q == ST_MAC) && (k_q != '0)) || (state_q == ST_DRAIN);
    hist_ctrl.shift  = (state_q == ST_STORE);
    hist_ctrl.rotate = (state_q == ST_MAC);
  end

  gmskrx_mac u_mac (
    .clk_i  (clk_i),
    .ctrl_i (mac_ctrl),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod),
    .acc_o  (acc)
  );

  gmskrx_hist #(
    .TAPS (TAPS)
  ) u_hist (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (hist_ctrl),
    .din_i  (scaled),
    .head_o (hist_head)
  );

  // ------------------------------------------------------------------
  // Sequencer: IDLE -> SCALE -> STORE -> MAC (one step per tap) -> DRAIN -> DONE.
  // ------------------------------------------------------------------
  always_comb begin
    state_d     = state_q;
    k_d         = k_q;
    cent_d      = cent_q;
    out_d       = out_q;
    // retire a pending beat once the sink takes it
    out_valid_d = out_valid_q && !filtered_ready_i;

    case (state_q)
      ST_IDLE: begin
        if (in_beat) begin
          cent_d = centered;
          // drop the sample outright while disabled
          if (enable_q) begin
            state_d = ST_SCALE;
          end
        end
      end
      ST_SCALE: begin
        state_d = ST_STORE;
      end
      ST_STORE: begin
        k_d     = '0;
        state_d = ST_MAC;
      end
      ST_MAC: begin
        k_d = k_q + KW'(1);
        if (k_q == KLAST) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        // hold the result until the output register is free
        if (!out_valid_q || filtered_ready_i) begin
          out_d       = result;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cent_q <= cent_d;
    out_q  <= out_d;
  end

  assign sample_ready_o   = (state_q == ST_IDLE);
  assign filtered_valid_o = out_valid_q;
  assign filtered_o       = out_q;

  // ------------------------------------------------------------------
  // Assertions
  // ------------------------------------------------------------------
  `GMSKRX_ASSERT_NEXT(a_drop_when_off, in_beat && !enable_q, state_q == ST_IDLE, "disabled sample started work")
  `GMSKRX_ASSERT_NEXT(a_start_when_on, in_beat && enable_q, state_q == ST_SCALE, "enabled sample not scaled")
  `GMSKRX_ASSERT_NEXT(a_mac_len, (state_q == ST_MAC) && (k_q == KLAST), state_q == ST_DRAIN, "tap loop overran")
  `GMSKRX_ASSERT_NOW(a_out_src, $rose(filtered_valid_o), $past(state_q == ST_DONE), "output beat without finished result")
  `GMSKRX_ASSERT_NEXT(a_no_overwrite, (state_q == ST_DONE) && out_valid_q && !filtered_ready_i, state_q == ST_DONE, "pending output overwritten")

endmodule
